@@ sv/byte_range_lock_table_top_assert.svh @@
// ----------------------------------------------------------------------------
// byte range lock table assertion macros
// shared property forms used by the lock table rtl
// ----------------------------------------------------------------------------
`ifndef BYTE_RANGE_LOCK_TABLE_TOP_ASSERT_SVH
`define BYTE_RANGE_LOCK_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define BLT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/blt_pkg.sv @@
// ----------------------------------------------------------------------------
// blt_pkg
// types, codes and helpers shared by the byte range lock table
// ----------------------------------------------------------------------------
package blt_pkg;

   localparam int MaxEntriesDefault = 64;
   localparam int ModeW    = 3;
   localparam int OwnerW   = 16;
   localparam int ByteW    = 32;
   localparam int StatusW  = 2;
   localparam int RemovedW = 7;

   // operation codes
   localparam logic [ModeW-1:0] MODE_ADD     = 3'd0;
   localparam logic [ModeW-1:0] MODE_OVERLAP = 3'd1;
   localparam logic [ModeW-1:0] MODE_FIND    = 3'd2;
   localparam logic [ModeW-1:0] MODE_REMOVE  = 3'd3;
   localparam logic [ModeW-1:0] MODE_CLEAR   = 3'd4;

   // status codes
   localparam logic [StatusW-1:0] STATUS_OK         = 2'd0;
   localparam logic [StatusW-1:0] STATUS_FULL       = 2'd1;
   localparam logic [StatusW-1:0] STATUS_OVERLAP    = 2'd2;
   localparam logic [StatusW-1:0] STATUS_NOT_LOCKED = 2'd3;

   typedef struct packed {
      logic [ModeW-1:0]  mode;
      logic [OwnerW-1:0] owner;
      logic [ByteW-1:0]  range_start;
      logic [ByteW-1:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [StatusW-1:0]  status;
      logic [RemovedW-1:0] removed_count;
   } rsp_type;

   typedef struct packed {
      logic [OwnerW-1:0] owner;
      logic [ByteW-1:0]  range_start;
      logic [ByteW-1:0]  length;
   } entry_type;

   // per-entry verdict from the compare unit
   typedef struct packed {
      logic owner_hit;
      logic exact_hit;
      logic overlap_hit;
   } cmp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // end of a range, one past its last byte, saturating at all ones
   function automatic logic [ByteW-1:0] range_end(input logic [ByteW-1:0] first,
                                                  input logic [ByteW-1:0] len);
      logic [ByteW:0] sum;
      sum = {1'b0, first} + {1'b0, len};
      return sum[ByteW] ? {ByteW{1'b1}} : sum[ByteW-1:0];
   endfunction

endpackage

@@ sv/byte_range_lock_table_top.sv @@
// ----------------------------------------------------------------------------
// byte_range_lock_table_top
// ordered table of locked byte ranges with add, overlap check, find,
// remove with compaction and clear of one owner
// ----------------------------------------------------------------------------
// usage
//   req channel: valid/ready, payload req_data (mode, owner, range_start,
//   byte_count); one request is taken only while the sequencer is idle
//   rsp channel: valid/ready, payload rsp_data (status, removed_count);
//   exactly one response per request, in request order
//   flow: an add or an unused mode goes from idle straight to the done
//   state, which loads the output register; overlap, find, remove and clear
//   walk every stored entry through the single-read-port table and the
//   shared compare unit, one entry per cycle, and then enter the done state;
//   the done state waits while a previous response is still held
//   requests: no new request is taken until the sequencer is back in idle,
//   so the walk over the table read port bounds how fast scans can follow.
//   remove and clear compact in the same walk: kept entries are written
//   back at a trailing write pointer, so order is preserved
//   reset: entry count goes to zero; table contents are left as they are,
//   no clearing pass is needed since only stored entries are read
//   stall: a finished response sits in the output register; the next
//   request is accepted meanwhile, and the sequencer waits only if its
//   own response is ready before the previous one has been taken
// ----------------------------------------------------------------------------
`include "byte_range_lock_table_top_assert.svh"

module byte_range_lock_table_top #(
   parameter int MaxEntries = blt_pkg::MaxEntriesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  blt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output blt_pkg::rsp_type rsp_data
);

   localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int CntW = $clog2(MaxEntries + 1);
   localparam logic [CntW-1:0] MaxCount = CntW'(MaxEntries);

   // sequencer state
   blt_pkg::state_type st_ff, st_in;

   // table occupancy and walk pointers
   logic [CntW-1:0] total_ff, total_in;
   logic [CntW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CntW-1:0] removed_ff, removed_in;
   logic            eval_ff, eval_in;

   // captured request and running verdicts
   blt_pkg::req_type          query_ff, query_in;
   logic [blt_pkg::ByteW-1:0] stop_ff, stop_in;
   logic                      full_ff, full_in;
   logic                      found_ff, found_in;
   logic                      overlap_ff, overlap_in;
   logic                      dropped_ff, dropped_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   blt_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // table ports
   logic               mem_wr_en;
   logic [IdxW-1:0]    mem_wr_addr;
   blt_pkg::entry_type mem_wr_data;
   logic [IdxW-1:0]    mem_rd_addr;
   blt_pkg::entry_type mem_rd_data;
   blt_pkg::cmp_type   verdict;

   logic req_fire;
   logic issue;
   logic compacting;
   logic drop;
   blt_pkg::entry_type req_entry;

   blt_mem #(
      .Depth (MaxEntries),
      .IdxW  (IdxW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   blt_cmp u_cmp (
      .entry      (mem_rd_data),
      .query      (query_ff),
      .query_stop (stop_ff),
      .verdict    (verdict)
   );

   assign req_ready = (st_ff == blt_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_entry.owner       = req_data.owner;
   assign req_entry.range_start = req_data.range_start;
   assign req_entry.length      = req_data.byte_count;

   // next state and datapath control
   always_comb begin
      st_in        = st_ff;
      total_in     = total_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      removed_in   = removed_ff;
      eval_in      = 1'b0;
      query_in     = query_ff;
      stop_in      = stop_ff;
      full_in      = full_ff;
      found_in     = found_ff;
      overlap_in   = overlap_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = total_ff[IdxW-1:0];
      mem_wr_data  = req_entry;
      mem_rd_addr  = rd_ptr_ff[IdxW-1:0];
      issue        = 1'b0;
      compacting   = (query_ff.mode == blt_pkg::MODE_REMOVE)
                     || (query_ff.mode == blt_pkg::MODE_CLEAR);
      drop         = 1'b0;

      unique case (st_ff)
         blt_pkg::ST_IDLE: begin
            if (req_fire) begin
               query_in   = req_data;
               stop_in    = blt_pkg::range_end(req_data.range_start, req_data.byte_count);
               rd_ptr_in  = '0;
               wr_ptr_in  = '0;
               removed_in = '0;
               found_in   = 1'b0;
               overlap_in = 1'b0;
               dropped_in = 1'b0;
               full_in    = 1'b0;
               if (req_data.mode == blt_pkg::MODE_ADD) begin
                  // append straight away, no walk needed
                  if (req_data.byte_count != '0) begin
                     if (total_ff >= MaxCount) begin
                        full_in = 1'b1;
                     end else begin
                        mem_wr_en = 1'b1;
                        total_in  = total_ff + 1'b1;
                     end
                  end
                  st_in = blt_pkg::ST_DONE;
               end else if ((req_data.mode == blt_pkg::MODE_OVERLAP)
                            || (req_data.mode == blt_pkg::MODE_FIND)
                            || (req_data.mode == blt_pkg::MODE_REMOVE)
                            || (req_data.mode == blt_pkg::MODE_CLEAR)) begin
                  st_in = blt_pkg::ST_SCAN;
               end else begin
                  st_in = blt_pkg::ST_DONE;
               end
            end
         end

         blt_pkg::ST_SCAN: begin
            // issue one table read per cycle
            issue = (rd_ptr_ff < total_ff);
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            eval_in = issue;
            // judge the entry read last cycle
            if (eval_ff) begin
               found_in   = found_ff || verdict.exact_hit;
               overlap_in = overlap_ff || verdict.overlap_hit;
               priority if (query_ff.mode == blt_pkg::MODE_REMOVE) begin
                  drop = verdict.exact_hit && !dropped_ff;
               end else if (query_ff.mode == blt_pkg::MODE_CLEAR) begin
                  drop = verdict.owner_hit;
               end else begin
                  drop = 1'b0;
               end
               if (drop) begin
                  dropped_in = 1'b1;
                  removed_in = removed_ff + 1'b1;
               end else if (compacting) begin
                  // kept entry slides down to the write pointer
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = wr_ptr_ff[IdxW-1:0];
                  mem_wr_data = mem_rd_data;
                  wr_ptr_in   = wr_ptr_ff + 1'b1;
               end
            end
            if (!issue && !eval_ff) begin
               if (compacting) begin
                  total_in = wr_ptr_ff;
               end
               st_in = blt_pkg::ST_DONE;
            end
         end

         blt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.removed_count = '0;
               unique case (query_ff.mode)
                  blt_pkg::MODE_ADD: begin
                     rsp_data_in.status = full_ff ? blt_pkg::STATUS_FULL
                                                  : blt_pkg::STATUS_OK;
                  end
                  blt_pkg::MODE_OVERLAP: begin
                     rsp_data_in.status = overlap_ff ? blt_pkg::STATUS_OVERLAP
                                                     : blt_pkg::STATUS_OK;
                  end
                  blt_pkg::MODE_FIND, blt_pkg::MODE_REMOVE: begin
                     rsp_data_in.status = found_ff ? blt_pkg::STATUS_OK
                                                   : blt_pkg::STATUS_NOT_LOCKED;
                  end
                  blt_pkg::MODE_CLEAR: begin
                     rsp_data_in.status        = blt_pkg::STATUS_OK;
                     rsp_data_in.removed_count = blt_pkg::RemovedW'(removed_ff);
                  end
                  default: begin
                     rsp_data_in.status = blt_pkg::STATUS_OK;
                  end
               endcase
               st_in = blt_pkg::ST_IDLE;
            end
         end

         default: begin
            st_in = blt_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= blt_pkg::ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         eval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         eval_ff      <= eval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      removed_ff  <= removed_in;
      query_ff    <= query_in;
      stop_ff     <= stop_in;
      full_ff     <= full_in;
      found_ff    <= found_in;
      overlap_ff  <= overlap_in;
      dropped_ff  <= dropped_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `BLT_ASSERT_NOW(a_total_bound, 1'b1, total_ff <= MaxCount,
      "entry count exceeds table depth")
   `BLT_ASSERT_NOW(a_wr_behind_rd, st_ff == blt_pkg::ST_SCAN, wr_ptr_ff <= rd_ptr_ff,
      "compaction write pointer overtook read pointer")
   `BLT_ASSERT_NOW(a_eval_in_scan, eval_ff, st_ff == blt_pkg::ST_SCAN,
      "entry evaluated outside a table walk")
   `BLT_ASSERT_NEXT(a_busy_after_req, req_fire, st_ff != blt_pkg::ST_IDLE,
      "sequencer idle right after taking a request")
   `BLT_ASSERT_NOW(a_removed_bound, st_ff == blt_pkg::ST_SCAN,
      (removed_ff + wr_ptr_ff) <= rd_ptr_ff,
      "more entries removed or kept than were read")

endmodule

@@ sv/blt_mem.sv @@
// ----------------------------------------------------------------------------
// blt_mem
// lock entry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module blt_mem #(
   parameter int Depth = blt_pkg::MaxEntriesDefault,
   parameter int IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IdxW-1:0]    wr_addr,
   input  blt_pkg::entry_type wr_data,
   input  logic [IdxW-1:0]    rd_addr,
   output blt_pkg::entry_type rd_data
);

   blt_pkg::entry_type mem [Depth];
   blt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/blt_cmp.sv @@
// ----------------------------------------------------------------------------
// blt_cmp
// shared compare unit, judges one stored entry against the request
// ----------------------------------------------------------------------------
module blt_cmp (
   input  blt_pkg::entry_type             entry,
   input  blt_pkg::req_type               query,
   input  logic [blt_pkg::ByteW-1:0]      query_stop,
   output blt_pkg::cmp_type               verdict
);

   logic [blt_pkg::ByteW-1:0] entry_stop;
   logic                      owner_eq;
   logic                      below;
   logic                      above;
   logic                      touch;

   always_comb begin
      entry_stop = blt_pkg::range_end(entry.range_start, entry.length);
      owner_eq   = (entry.owner == query.owner);
      below      = (entry.range_start < query.range_start);
      above      = (entry.range_start > query.range_start);
      // lower start: its end reaches past ours; higher start: ours reaches it
      priority if (below) begin
         touch = (entry_stop > query.range_start);
      end else if (above) begin
         touch = (query_stop > entry.range_start);
      end else begin
         touch = 1'b1;
      end
      verdict.owner_hit   = owner_eq;
      verdict.exact_hit   = owner_eq && (entry.range_start == query.range_start)
                            && (entry.length == query.byte_count);
      verdict.overlap_hit = owner_eq && touch && (query.byte_count != '0);
   end

endmodule
